// ===== sv/fsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Fader scan package
// Shared constants, the command passed from the front end to the back end,
// and the fader sequencing tables.
// ----------------------------------------------------------------------------
package fsdf_pkg;

    localparam int FADER_COUNT = 8;
    localparam int FADER_W     = 3;
    localparam int SAMPLE_W    = 7;
    localparam int ADC_W       = 8;
    localparam int PRIME_W     = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        CMD_SKIP,
        CMD_PRIME,
        CMD_AVG
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [FADER_W-1:0]    fader;
        logic [SAMPLE_W-1:0]   value;
        logic [FADER_W-1:0]    mux_code;
    } t_cmd;

    // Scan order 0,1,2,3,5,4,7,6.
    function automatic logic [FADER_W-1:0] next_fader(input logic [FADER_W-1:0] f);
        logic [FADER_W-1:0] r;
        unique case (f)
            3'd0:    r = 3'd1;
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd3;
            3'd3:    r = 3'd5;
            3'd4:    r = 3'd7;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd0;
            3'd7:    r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Multiplexer select pins for each fader.
    function automatic logic [FADER_W-1:0] pin_code(input logic [FADER_W-1:0] f);
        logic [FADER_W-1:0] r;
        unique case (f)
            3'd0:    r = 3'b000;
            3'd1:    r = 3'b001;
            3'd2:    r = 3'b011;
            3'd3:    r = 3'b010;
            3'd4:    r = 3'b111;
            3'd5:    r = 3'b110;
            3'd6:    r = 3'b100;
            3'd7:    r = 3'b101;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/fsdf_front.sv =====
// ----------------------------------------------------------------------------
// Fader scan front end
// Accepts ADC samples, tracks priming and sample grouping, forms the group
// average and decides the next fader and multiplexer pins.
// ----------------------------------------------------------------------------
module fsdf_front #(
    parameter int AVERAGE_SAMPLES = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [fsdf_pkg::ADC_W-1:0]   i_adc,
    output fsdf_pkg::t_cmd               o_cmd
);

    localparam int SUM_W       = fsdf_pkg::SAMPLE_W + $clog2(AVERAGE_SAMPLES);
    localparam int CNT_W       = (AVERAGE_SAMPLES > 1) ? $clog2(AVERAGE_SAMPLES) : 1;
    localparam int RECIP_SHIFT = SUM_W + $clog2(AVERAGE_SAMPLES);
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam longint RECIP_L = ((longint'(1) << RECIP_SHIFT) + AVERAGE_SAMPLES - 1)
                                 / AVERAGE_SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W      = SUM_W + RECIP_W;

    logic [fsdf_pkg::FADER_W-1:0]  r_fader;
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_count;
    logic [fsdf_pkg::PRIME_W-1:0]  r_prime_cnt;

    logic [fsdf_pkg::SAMPLE_W-1:0] sample;
    logic                          priming;
    logic                          group_done;
    logic [SUM_W-1:0]              sum_next;
    logic [PROD_W-1:0]             product;
    logic [fsdf_pkg::SAMPLE_W-1:0] avg;
    logic [fsdf_pkg::FADER_W-1:0]  fader_next;

    assign sample     = i_adc[fsdf_pkg::ADC_W-1:1];
    assign priming    = r_prime_cnt < fsdf_pkg::PRIME_W'(fsdf_pkg::FADER_COUNT);
    assign group_done = (r_count == CNT_W'(AVERAGE_SAMPLES - 1));
    assign sum_next   = r_sum + SUM_W'(sample);
    // Truncating division by a constant, done as a reciprocal multiply.
    assign product    = PROD_W'(sum_next) * PROD_W'(RECIP);
    assign avg        = fsdf_pkg::SAMPLE_W'(product >> RECIP_SHIFT);
    assign fader_next = (priming || group_done) ? fsdf_pkg::next_fader(r_fader) : r_fader;

    always_comb begin
        o_cmd.fader    = r_fader;
        o_cmd.mux_code = fsdf_pkg::pin_code(fader_next);
        if (priming) begin
            o_cmd.kind  = fsdf_pkg::CMD_PRIME;
            o_cmd.value = sample;
        end else if (group_done) begin
            o_cmd.kind  = fsdf_pkg::CMD_AVG;
            o_cmd.value = avg;
        end else begin
            o_cmd.kind  = fsdf_pkg::CMD_SKIP;
            o_cmd.value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fader     <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_prime_cnt <= '0;
        end else if (i_accept) begin
            r_fader <= fader_next;
            if (priming) begin
                r_prime_cnt <= r_prime_cnt + 1'b1;
            end else if (group_done) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= sum_next;
                r_count <= r_count + 1'b1;
            end
        end
    end

    a_prime_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prime_cnt <= fsdf_pkg::PRIME_W'(fsdf_pkg::FADER_COUNT))
        else $error("priming count ran past the fader count");

    a_prime_no_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        priming |-> (r_sum == '0 && r_count == '0))
        else $error("sample group started during priming");

endmodule

// ===== sv/fsdf_queue.sv =====
// ----------------------------------------------------------------------------
// Fader scan command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fsdf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fsdf_pkg::t_cmd  i_data,
    input  logic            i_pop,
    output fsdf_pkg::t_cmd  o_data,
    output logic            o_full,
    output logic            o_empty
);

    fsdf_pkg::t_cmd                r_mem [fsdf_pkg::QUEUE_DEPTH];
    logic [fsdf_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [fsdf_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [fsdf_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == fsdf_pkg::QCNT_W'(fsdf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/fsdf_back.sv =====
// ----------------------------------------------------------------------------
// Fader scan back end
// Holds the recent values of each fader, drops repeats, updates the ring
// slots and drives the registered result.
// ----------------------------------------------------------------------------
module fsdf_back #(
    parameter int RECENT_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fsdf_pkg::t_cmd                  i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  logic                            i_tready,
    output logic                            o_tvalid,
    output logic                            o_update,
    output logic [fsdf_pkg::FADER_W-1:0]    o_mux_code,
    output logic [fsdf_pkg::FADER_W-1:0]    o_fader_index,
    output logic [fsdf_pkg::SAMPLE_W-1:0]   o_fader_value
);

    localparam int PTR_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

    logic [fsdf_pkg::SAMPLE_W-1:0] r_recent [fsdf_pkg::FADER_COUNT][RECENT_DEPTH];
    logic [PTR_W-1:0]              r_ring   [fsdf_pkg::FADER_COUNT];

    logic                          r_tvalid;
    logic                          r_update;
    logic [fsdf_pkg::FADER_W-1:0]  r_mux_code;
    logic [fsdf_pkg::FADER_W-1:0]  r_fader_index;
    logic [fsdf_pkg::SAMPLE_W-1:0] r_fader_value;

    logic                          seen;
    logic [PTR_W-1:0]              ptr;
    logic [PTR_W-1:0]              ptr_next;
    logic                          is_new;

    assign o_pop    = !i_empty && (!r_tvalid || i_tready);
    assign ptr      = r_ring[i_cmd.fader];
    assign ptr_next = (ptr == PTR_W'(RECENT_DEPTH - 1)) ? '0 : ptr + 1'b1;
    assign is_new   = (i_cmd.kind == fsdf_pkg::CMD_AVG) && !seen;

    // Compare against every recent slot of the fader at once.
    always_comb begin
        seen = 1'b0;
        for (int k = 0; k < RECENT_DEPTH; k++) begin
            if (r_recent[i_cmd.fader][k] == i_cmd.value) begin
                seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.kind == fsdf_pkg::CMD_PRIME) begin
                for (int k = 0; k < RECENT_DEPTH; k++) begin
                    r_recent[i_cmd.fader][k] <= i_cmd.value;
                end
            end else if (is_new) begin
                r_recent[i_cmd.fader][ptr] <= i_cmd.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < fsdf_pkg::FADER_COUNT; f++) begin
                r_ring[f] <= '0;
            end
            r_tvalid      <= 1'b0;
            r_update      <= 1'b0;
            r_mux_code    <= '0;
            r_fader_index <= '0;
            r_fader_value <= '0;
        end else begin
            if (o_pop) begin
                r_tvalid   <= 1'b1;
                r_mux_code <= i_cmd.mux_code;
                if (i_cmd.kind == fsdf_pkg::CMD_PRIME) begin
                    r_ring[i_cmd.fader] <= '0;
                end else if (is_new) begin
                    r_ring[i_cmd.fader] <= ptr_next;
                end
                if (is_new) begin
                    r_update      <= 1'b1;
                    r_fader_index <= i_cmd.fader;
                    r_fader_value <= i_cmd.value;
                end else begin
                    r_update      <= 1'b0;
                    r_fader_index <= '0;
                    r_fader_value <= '0;
                end
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    assign o_tvalid      = r_tvalid;
    assign o_update      = r_update;
    assign o_mux_code    = r_mux_code;
    assign o_fader_index = r_fader_index;
    assign o_fader_value = r_fader_value;

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tvalid && !r_update) |-> (r_fader_index == '0 && r_fader_value == '0))
        else $error("fields not cleared on a result without update");

    a_new_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_new) |=> (r_tvalid && r_update))
        else $error("new average was not reported");

endmodule

// ===== sv/fader_scan_dedup_filter.sv =====
// ----------------------------------------------------------------------------
// Fader scan and repeat filter
// Scans eight faders, averages their samples and reports changed values.
// ----------------------------------------------------------------------------
// One ADC sample is taken per cycle while the queue has room, and each sample
// yields exactly one result, held in the two-entry command queue between the
// sampling front end and the filtering back end. The back end pops one command
// per cycle while its registered output stage is empty or being read. The
// first eight samples prime the recent-value store, one per fader, and report
// no update; fader values are only compared after that.
// ----------------------------------------------------------------------------
module fader_scan_dedup_filter #(
    parameter int AVERAGE_SAMPLES = 2,
    parameter int RECENT_DEPTH    = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] adc_high_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] mux_code, [5:3] fader_index,
                                        // [12:6] fader_value, [15:13] zero
    output logic        m_axis_tuser    // [0] update_valid
);

    fsdf_pkg::t_cmd                front_cmd;
    fsdf_pkg::t_cmd                queue_cmd;
    logic                          accept;
    logic                          q_full;
    logic                          q_empty;
    logic                          pop;
    logic [fsdf_pkg::FADER_W-1:0]  mux_code;
    logic [fsdf_pkg::FADER_W-1:0]  fader_index;
    logic [fsdf_pkg::SAMPLE_W-1:0] fader_value;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    fsdf_front #(
        .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_adc    (s_axis_tdata),
        .o_cmd    (front_cmd)
    );

    fsdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fsdf_back #(
        .RECENT_DEPTH(RECENT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_tready      (m_axis_tready),
        .o_tvalid      (m_axis_tvalid),
        .o_update      (m_axis_tuser),
        .o_mux_code    (mux_code),
        .o_fader_index (fader_index),
        .o_fader_value (fader_value)
    );

    assign m_axis_tdata = {3'b000, fader_value, fader_index, mux_code};

endmodule
